// ===== sv/tms_pkg.sv =====
// ============================================================================
// Turing machine step engine package
// Shared sizes, field layouts, codes and controller states.
// ============================================================================
package tms_pkg;

   // Machine dimensions.
   localparam int STATE_COUNT = 16;
   localparam int TAPE_CELLS  = 1024;
   localparam int SYMBOL_BITS = 8;

   localparam int STATE_BITS = $clog2(STATE_COUNT);
   localparam int TAPE_BITS  = $clog2(TAPE_CELLS);
   localparam int SYM_COUNT  = 1 << SYMBOL_BITS;
   localparam int TT_DEPTH   = STATE_COUNT * SYM_COUNT;
   localparam int TT_BITS    = $clog2(TT_DEPTH);

   // The clearing sweep covers the larger of the two memories.
   localparam int CLR_DEPTH = (TT_DEPTH > TAPE_CELLS) ? TT_DEPTH : TAPE_CELLS;
   localparam int CLR_BITS  = $clog2(CLR_DEPTH);

   // Fixed field widths of the channels.
   localparam int OP_W     = 3;
   localparam int STATE_W  = 4;
   localparam int SYM_W    = 8;
   localparam int DIR_W    = 2;
   localparam int KIND_W   = 2;
   localparam int CELL_W   = 10;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 32;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_START  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEPS   = 2'd3;

   localparam logic [STATE_W-1:0] START_STATE_RESET = 4'd0;
   localparam logic [SYM_W-1:0]   BLANK_RESET       = 8'd95;
   localparam logic [CELL_W-1:0]  HEAD_START_RESET  = 10'd512;
   localparam logic [COUNT_W-1:0] MAX_STEPS_RESET   = 32'd100000;

   localparam logic [TAPE_BITS-1:0] LAST_CELL  = TAPE_BITS'(TAPE_CELLS - 1);
   localparam logic [TAPE_BITS-1:0] HEAD_RESET =
      (int'(HEAD_START_RESET) >= TAPE_CELLS) ? LAST_CELL : TAPE_BITS'(HEAD_START_RESET);

   // Operation codes.
   localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
   localparam logic [OP_W-1:0] OP_KIND    = 3'd1;
   localparam logic [OP_W-1:0] OP_WRITE   = 3'd2;
   localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
   localparam logic [OP_W-1:0] OP_STEP    = 3'd4;
   localparam logic [OP_W-1:0] OP_READ    = 3'd5;

   // Run status codes.
   localparam logic [STATUS_W-1:0] STATUS_READY    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ACCEPT   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_OFF_TAPE = 3'd4;

   // State kinds.
   localparam logic [KIND_W-1:0] KIND_NORMAL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

   // Head moves; any other code keeps the head in place.
   localparam logic [DIR_W-1:0] MOVE_LEFT  = 2'd0;
   localparam logic [DIR_W-1:0] MOVE_RIGHT = 2'd1;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [STATE_W-1:0] state_id;
      logic [SYM_W-1:0]   match_symbol;
      logic [STATE_W-1:0] next_state;
      logic [SYM_W-1:0]   out_symbol;
      logic [DIR_W-1:0]   move_dir;
      logic [KIND_W-1:0]  state_kind;
      logic [CELL_W-1:0]  cell_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] run_status;
      logic [STATE_W-1:0]  current_state;
      logic [CELL_W-1:0]   head_position;
      logic [SYM_W-1:0]    cell_symbol;
      logic [COUNT_W-1:0]  steps_taken;
   } rsp_type;

   // One transition table entry.
   typedef struct packed {
      logic                   valid;
      logic [STATE_BITS-1:0]  next_state;
      logic [SYMBOL_BITS-1:0] out_sym;
      logic [DIR_W-1:0]       dir;
   } trans_type;

   // One tape cell.
   typedef struct packed {
      logic                   written;
      logic [SYMBOL_BITS-1:0] sym;
   } cell_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_FETCH,
      ST_APPLY,
      ST_KIND,
      ST_SHOW,
      ST_OUT
   } fsm_type;

endpackage

// ===== sv/tms_ram.sv =====
// ============================================================================
// Turing machine step engine RAM
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ============================================================================
module tms_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 256,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/turing_machine_step_engine.sv =====
// ============================================================================
// Turing machine step engine
// Single-tape deterministic Turing machine built around two memories.
// ============================================================================
// Each request beat carries one operation: load a transition, set the kind of
// a state, write or read a tape cell, restart the run, or execute one step.
// Every request beat produces exactly one response beat with the run status,
// the machine state, the head position, a symbol and the step count.
// The configuration port writes start state, blank symbol, head start and
// the step limit, one register per write; it is to be used only while the
// engine is idle, which the engine itself does not enforce. The engine
// handles one request at a time and takes a new request only after it has
// registered the response of the last. A step runs through a chain of
// dependent memory accesses: tape cell read, then transition entry read,
// then tape write, and a final tape read for the shown symbol.
// After reset the engine sweeps both memories, one entry a cycle, over the
// transition table depth (4096 entries) before it raises req_ready.
// A response waits in its output register while rsp_ready is low; the engine
// still takes one more request, runs it, and holds it in its last stage
// until the waiting beat drains.
// ============================================================================
module turing_machine_step_engine
   import tms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Controller and run state.
   fsm_type                fsm_ff, fsm_in;
   logic [CLR_BITS-1:0]    clr_ff, clr_in;
   req_type                req_ff, req_in;
   logic [STATE_BITS-1:0]  state_ff, state_in;
   logic [TAPE_BITS-1:0]   head_ff, head_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [KIND_W-1:0]      kind_ff [STATE_COUNT];
   logic [KIND_W-1:0]      kind_in [STATE_COUNT];
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Configuration registers.
   logic [STATE_W-1:0]     start_ff, start_in;
   logic [SYM_W-1:0]       blank_ff, blank_in;
   logic [CELL_W-1:0]      hstart_ff, hstart_in;
   logic [COUNT_W-1:0]     max_ff, max_in;

   // Memory ports.
   logic                   tape_we, tape_re;
   logic [TAPE_BITS-1:0]   tape_waddr, tape_raddr;
   cell_type               tape_wdata, tape_rdata;
   logic                   tt_we, tt_re;
   logic [TT_BITS-1:0]     tt_waddr, tt_raddr;
   trans_type              tt_wdata, tt_rdata;

   // Derived values.
   logic [SYMBOL_BITS-1:0] blank_sym;
   logic [SYMBOL_BITS-1:0] tape_sym;
   logic [TAPE_BITS-1:0]   head_init;
   logic [TT_BITS-1:0]     load_addr;
   logic                   cell_in_range;

   tms_ram #(
      .WIDTH ($bits(cell_type)),
      .DEPTH (TAPE_CELLS)
   ) u_tape (
      .clock (clock),
      .we    (tape_we),
      .waddr (tape_waddr),
      .wdata (tape_wdata),
      .re    (tape_re),
      .raddr (tape_raddr),
      .rdata (tape_rdata)
   );

   tms_ram #(
      .WIDTH ($bits(trans_type)),
      .DEPTH (TT_DEPTH)
   ) u_trans (
      .clock (clock),
      .we    (tt_we),
      .waddr (tt_waddr),
      .wdata (tt_wdata),
      .re    (tt_re),
      .raddr (tt_raddr),
      .rdata (tt_rdata)
   );

   assign blank_sym = blank_ff[SYMBOL_BITS-1:0];

   // A cell that was never written reads as the blank symbol.
   assign tape_sym = tape_rdata.written ? tape_rdata.sym : blank_sym;

   // A head start beyond the tape saturates to the last cell.
   assign head_init = (32'(hstart_ff) >= TAPE_CELLS) ? LAST_CELL : TAPE_BITS'(hstart_ff);

   assign load_addr = {req_ff.state_id[STATE_BITS-1:0],
                       req_ff.match_symbol[SYMBOL_BITS-1:0]};

   assign cell_in_range = (32'(req_ff.cell_index) < TAPE_CELLS);

   // Configuration writes are taken in any controller state.
   always_comb begin
      start_in  = start_ff;
      blank_in  = blank_ff;
      hstart_in = hstart_ff;
      max_in    = max_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_STATE: start_in  = csr_wdata[STATE_W-1:0];
            CSR_BLANK:       blank_in  = csr_wdata[SYM_W-1:0];
            CSR_HEAD_START:  hstart_in = csr_wdata[CELL_W-1:0];
            CSR_MAX_STEPS:   max_in    = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Controller: next state, memory controls and run state updates.
   always_comb begin
      fsm_in       = fsm_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      kind_in      = kind_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      tape_we      = 1'b0;
      tape_waddr   = head_ff;
      tape_wdata   = '0;
      tape_re      = 1'b0;
      tape_raddr   = head_ff;
      tt_we        = 1'b0;
      tt_waddr     = load_addr;
      tt_wdata     = '0;
      tt_re        = 1'b0;
      tt_raddr     = load_addr;

      case (fsm_ff)
         ST_CLEAR: begin
            // Mark every transition invalid and every cell unwritten.
            tt_we    = 1'b1;
            tt_waddr = clr_ff[TT_BITS-1:0];
            if (32'(clr_ff) < TAPE_CELLS) begin
               tape_we    = 1'b1;
               tape_waddr = clr_ff[TAPE_BITS-1:0];
            end
            clr_in = clr_ff + CLR_BITS'(1);
            if (clr_ff == CLR_BITS'(CLR_DEPTH - 1)) begin
               fsm_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               fsm_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            fsm_in = ST_SHOW;
            case (req_ff.op)
               OP_LOAD: begin
                  tt_re  = 1'b1;
                  fsm_in = ST_LOAD;
               end
               OP_KIND: begin
                  if (req_ff.state_kind != KIND_NONE) begin
                     kind_in[req_ff.state_id[STATE_BITS-1:0]] = req_ff.state_kind;
                  end
               end
               OP_WRITE: begin
                  if (cell_in_range) begin
                     tape_we    = 1'b1;
                     tape_waddr = TAPE_BITS'(req_ff.cell_index);
                     tape_wdata = '{written: 1'b1,
                                    sym: req_ff.match_symbol[SYMBOL_BITS-1:0]};
                  end
               end
               OP_RESTART: begin
                  state_in  = start_ff[STATE_BITS-1:0];
                  head_in   = head_init;
                  count_in  = '0;
                  status_in = STATUS_READY;
               end
               OP_STEP: begin
                  if (status_ff == STATUS_READY) begin
                     if (kind_ff[state_ff] == KIND_ACCEPT) begin
                        status_in = STATUS_ACCEPT;
                     end else if (kind_ff[state_ff] == KIND_REJECT) begin
                        status_in = STATUS_REJECT;
                     end else if (count_ff >= max_ff) begin
                        status_in = STATUS_LIMIT;
                     end else begin
                        tape_re = 1'b1;
                        fsm_in  = ST_FETCH;
                     end
                  end
               end
               default: ;
            endcase
         end

         ST_LOAD: begin
            // The first transition loaded for a pair is kept.
            if (!tt_rdata.valid) begin
               tt_we    = 1'b1;
               tt_wdata = '{valid: 1'b1,
                            next_state: req_ff.next_state[STATE_BITS-1:0],
                            out_sym: req_ff.out_symbol[SYMBOL_BITS-1:0],
                            dir: req_ff.move_dir};
            end
            fsm_in = ST_SHOW;
         end

         ST_FETCH: begin
            tt_re    = 1'b1;
            tt_raddr = {state_ff, tape_sym};
            fsm_in   = ST_APPLY;
         end

         ST_APPLY: begin
            fsm_in = ST_SHOW;
            if (!tt_rdata.valid) begin
               status_in = STATUS_REJECT;
            end else begin
               tape_we    = 1'b1;
               tape_waddr = head_ff;
               tape_wdata = '{written: 1'b1, sym: tt_rdata.out_sym};
               state_in   = tt_rdata.next_state;
               if (tt_rdata.dir == MOVE_LEFT && head_ff == '0) begin
                  status_in = STATUS_OFF_TAPE;
               end else if (tt_rdata.dir == MOVE_RIGHT && head_ff == LAST_CELL) begin
                  status_in = STATUS_OFF_TAPE;
               end else begin
                  if (tt_rdata.dir == MOVE_LEFT) begin
                     head_in = head_ff - TAPE_BITS'(1);
                  end else if (tt_rdata.dir == MOVE_RIGHT) begin
                     head_in = head_ff + TAPE_BITS'(1);
                  end
                  count_in = count_ff + COUNT_W'(1);
                  fsm_in   = ST_KIND;
               end
            end
         end

         ST_KIND: begin
            // Kind of the state just entered.
            if (kind_ff[state_ff] == KIND_ACCEPT) begin
               status_in = STATUS_ACCEPT;
            end else if (kind_ff[state_ff] == KIND_REJECT) begin
               status_in = STATUS_REJECT;
            end
            fsm_in = ST_SHOW;
         end

         ST_SHOW: begin
            tape_re = 1'b1;
            if (req_ff.op == OP_READ) begin
               tape_raddr = TAPE_BITS'(req_ff.cell_index);
            end
            fsm_in = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.run_status    = status_ff;
               rsp_in.current_state = STATE_W'(state_ff);
               rsp_in.head_position = CELL_W'(head_ff);
               rsp_in.steps_taken   = count_ff;
               if (req_ff.op == OP_READ && !cell_in_range) begin
                  rsp_in.cell_symbol = SYM_W'(blank_sym);
               end else begin
                  rsp_in.cell_symbol = SYM_W'(tape_sym);
               end
               fsm_in = ST_IDLE;
            end
         end

         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_CLEAR;
         clr_ff       <= '0;
         state_ff     <= '0;
         head_ff      <= HEAD_RESET;
         count_ff     <= '0;
         status_ff    <= STATUS_READY;
         kind_ff      <= '{default: KIND_NORMAL};
         rsp_valid_ff <= 1'b0;
         start_ff     <= START_STATE_RESET;
         blank_ff     <= BLANK_RESET;
         hstart_ff    <= HEAD_START_RESET;
         max_ff       <= MAX_STEPS_RESET;
      end else begin
         fsm_ff       <= fsm_in;
         clr_ff       <= clr_in;
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         blank_ff     <= blank_in;
         hstart_ff    <= hstart_in;
         max_ff       <= max_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Only one request is in flight at a time.
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // The step count only grows by one or returns to zero on restart.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
         |-> ((count_ff == $past(count_ff) + COUNT_W'(1)) || (count_ff == '0)))
      else $error("step count changed by more than one step");

   // A finished run keeps its status until a restart.
   a_status_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && ($past(status_ff) != STATUS_READY) && (status_ff != $past(status_ff)))
         |-> $past(fsm_ff == ST_EXEC && req_ff.op == OP_RESTART))
      else $error("finished run status left without restart");

   // A response is raised only from the output stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fsm_ff == ST_OUT))
      else $error("response raised outside the output stage");

endmodule
